// ===== rtl/core/atpd_pkg.sv =====
// Package for the adaptive threshold presence detector.
// Holds the word types, the op and band codes and the threshold table.
// No dependencies.
package atpd_pkg;

  localparam int SAMPLE_BITS = 12;

  localparam logic OP_PULSE = 1'b0;
  localparam logic OP_TICK  = 1'b1;

  // ambient band codes; BAND_KEEP leaves the previous threshold in force
  localparam logic [2:0] BAND_KEEP = 3'd0;
  localparam logic [2:0] BAND_1000 = 3'd1;
  localparam logic [2:0] BAND_1200 = 3'd2;
  localparam logic [2:0] BAND_1400 = 3'd3;
  localparam logic [2:0] BAND_1600 = 3'd4;
  localparam logic [2:0] BAND_1800 = 3'd5;
  localparam logic [2:0] BAND_2000 = 3'd6;
  localparam logic [2:0] BAND_2500 = 3'd7;

  localparam logic [SAMPLE_BITS-1:0] THRESHOLD_RESET = 12'd100;

  localparam logic [15:0] HOLD_TICKS_RESET    = 16'd3000;
  localparam logic [3:0]  CONFIRM_COUNT_RESET = 4'd2;
  localparam logic [12:0] INVALID_LIMIT_RESET = 13'd4095;

  // register indexes on the configuration port
  localparam logic [1:0] REG_HOLD_TICKS    = 2'd0;
  localparam logic [1:0] REG_CONFIRM_COUNT = 2'd1;
  localparam logic [1:0] REG_INVALID_LIMIT = 2'd2;

  typedef struct packed {
    logic                   op;
    logic [SAMPLE_BITS-1:0] signal_sample;
    logic [SAMPLE_BITS-1:0] ambient_sample;
  } atpd_in_t;

  typedef struct packed {
    logic                   detect_out;
    logic [SAMPLE_BITS-1:0] threshold;
    logic                   hit;
  } atpd_out_t;

  // classified word as it sits in the queue
  typedef struct packed {
    logic                   op;
    logic [SAMPLE_BITS-1:0] signal_sample;
    logic [2:0]             band;
  } atpd_entry_t;

  typedef struct packed {
    logic [15:0] hold_ticks;
    logic [3:0]  confirm_count;
    logic [12:0] invalid_limit;
  } atpd_cfg_t;

  typedef struct packed {
    logic        valid;
    atpd_entry_t entry;
  } atpd_q_out_t;

  function automatic logic [2:0] band_of(input logic [SAMPLE_BITS-1:0] amb);
    logic [2:0] band;
    band = BAND_KEEP;
    if (amb >= 12'd3500 && amb < 12'd4095)      band = BAND_2500;
    else if (amb >= 12'd3200 && amb < 12'd3500) band = BAND_2000;
    else if (amb >= 12'd3000 && amb < 12'd3200) band = BAND_1800;
    else if (amb >= 12'd2700 && amb < 12'd3000) band = BAND_1600;
    else if (amb >= 12'd2500 && amb < 12'd2700) band = BAND_1400;
    else if (amb >= 12'd2200 && amb < 12'd2500) band = BAND_1200;
    else if (amb >= 12'd2000 && amb < 12'd2200) band = BAND_1000;
    return band;
  endfunction

  function automatic logic [SAMPLE_BITS-1:0] band_threshold(
    input logic [2:0]             band,
    input logic [SAMPLE_BITS-1:0] prev
  );
    logic [SAMPLE_BITS-1:0] thr;
    case (band)
      BAND_1000: thr = 12'd1000;
      BAND_1200: thr = 12'd1200;
      BAND_1400: thr = 12'd1400;
      BAND_1600: thr = 12'd1600;
      BAND_1800: thr = 12'd1800;
      BAND_2000: thr = 12'd2000;
      BAND_2500: thr = 12'd2500;
      default:   thr = prev;
    endcase
    return thr;
  endfunction

endpackage

// ===== rtl/core/atpd_front.sv =====
// Front end: takes input words and classifies the ambient sample into a band.
// Depends on atpd_pkg.
module atpd_front
  import atpd_pkg::*;
(
  input  logic        in_valid,
  input  atpd_in_t    in_data,
  input  logic        q_full,
  output logic        in_stall,
  output logic        push,
  output atpd_entry_t push_entry
);

  assign in_stall = q_full;
  assign push     = in_valid & ~q_full;

  always_comb begin
    push_entry.op            = in_data.op;
    push_entry.signal_sample = in_data.signal_sample;
    // band only matters for pulses
    push_entry.band = (in_data.op == OP_PULSE) ? band_of(in_data.ambient_sample) : BAND_KEEP;
  end

endmodule

// ===== rtl/core/atpd_queue.sv =====
// Short FIFO of classified words between front and back end.
// Depends on atpd_pkg.
module atpd_queue
  import atpd_pkg::*;
#(
  parameter int DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  input  atpd_entry_t push_entry,
  input  logic        pop,
  output logic        full,
  output atpd_q_out_t q_out
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  atpd_entry_t mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  assign full        = (count_r == CNT_W'(DEPTH));
  assign q_out.valid = (count_r != '0);
  assign q_out.entry = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ptr_inc(wr_ptr_r) : wr_ptr_r;
    rd_ptr_nxt = pop ? ptr_inc(rd_ptr_r) : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) count_nxt = count_r + CNT_W'(1);
    else if (!push && pop) count_nxt = count_r - CNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_entry;
  end

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && full)) else $error("queue written while full");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !(pop && !q_out.valid)) else $error("queue read while empty");
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH)) else $error("queue count out of range");

endmodule

// ===== rtl/core/atpd_back.sv =====
// Back end: threshold, hit test, confirm and hold counters, output register.
// Depends on atpd_pkg.
module atpd_back
  import atpd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  atpd_cfg_t   cfg,
  input  atpd_q_out_t q_out,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_stall,
  output atpd_out_t   out_data
);

  logic                   active_r, active_nxt;
  logic [3:0]             hit_count_r, hit_count_nxt;
  logic [SAMPLE_BITS-1:0] thr_r, thr_nxt;
  logic [15:0]            hold_r, hold_nxt;
  logic                   level_r, level_nxt;
  logic                   out_valid_r, out_valid_nxt;
  atpd_out_t              out_data_r, out_data_nxt;

  logic [SAMPLE_BITS-1:0] thr_sel;
  logic                   hit;
  atpd_entry_t            e;

  assign e   = q_out.entry;
  assign pop = q_out.valid & (~out_valid_r | ~out_stall);

  always_comb begin
    active_nxt    = active_r;
    hit_count_nxt = hit_count_r;
    thr_nxt       = thr_r;
    hold_nxt      = hold_r;
    level_nxt     = level_r;
    hit           = 1'b0;
    thr_sel       = band_threshold(e.band, thr_r);
    if (pop) begin
      if (e.op == OP_PULSE) begin
        thr_nxt = thr_sel;
        hit = (e.signal_sample >= thr_sel) &&
              (({1'b0, e.signal_sample} + 13'd1) < cfg.invalid_limit);
        if (hit) begin
          if (!active_r) begin
            if (({1'b0, hit_count_r} + 5'd1) >= {1'b0, cfg.confirm_count}) begin
              hold_nxt      = '0;
              level_nxt     = 1'b1;
              active_nxt    = 1'b1;
              hit_count_nxt = '0;
            end else begin
              hit_count_nxt = hit_count_r + 4'd1;
            end
          end else begin
            hold_nxt = '0;
          end
        end
      end else begin
        if (({1'b0, hold_r} + 17'd1) >= {1'b0, cfg.hold_ticks}) begin
          hold_nxt   = '0;
          level_nxt  = 1'b0;
          active_nxt = 1'b0;
        end else begin
          hold_nxt = hold_r + 16'd1;
        end
      end
    end
    out_valid_nxt           = pop | (out_valid_r & out_stall);
    out_data_nxt            = out_data_r;
    if (pop) begin
      out_data_nxt.detect_out = level_nxt;
      out_data_nxt.threshold  = thr_nxt;
      out_data_nxt.hit        = hit;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= 1'b0;
      hit_count_r <= '0;
      thr_r       <= THRESHOLD_RESET;
      hold_r      <= '0;
      level_r     <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      active_r    <= active_nxt;
      hit_count_r <= hit_count_nxt;
      thr_r       <= thr_nxt;
      hold_r      <= hold_nxt;
      level_r     <= level_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_active_level: assert property (@(posedge clk) disable iff (!rst_n)
    active_r |-> level_r) else $error("active mode with output released");
  a_active_count: assert property (@(posedge clk) disable iff (!rst_n)
    active_r |-> (hit_count_r == '0)) else $error("hit count kept in active mode");
  a_enter_hold: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(active_r) |-> (hold_r == '0)) else $error("hold counter not cleared on entry");
  a_hold_out: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |=> (out_valid_r && $stable(out_data_r)))
    else $error("stalled result lost");

endmodule

// ===== rtl/core/adaptive_threshold_presence_detector_top.sv =====
// Top level of the adaptive threshold presence detector.
// Depends on atpd_pkg, atpd_front, atpd_queue and atpd_back.
// A word accepted is written into the queue and then taken into the output
//   register. Throughput: one word per cycle while out_stall is low.
// The queue (QUEUE_DEPTH words) lets front and back stall separately.
// Reset (rst_n low, synchronous): queue empty, no result pending, registers at
//   hold 3000, confirm 2, limit 4095; threshold 100, idle, detect level high.
module adaptive_threshold_presence_detector_top
  import atpd_pkg::*;
#(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  atpd_in_t    in_data,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output atpd_out_t   out_data,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // ---------------------------------------------------------------
  // configuration registers; word index from the byte address
  // ---------------------------------------------------------------
  atpd_cfg_t  cfg_r, cfg_nxt;
  logic       cfg_wr;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign cfg_wr  = psel & penable & pwrite & pready;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr) begin
      case (reg_idx)
        REG_HOLD_TICKS:    cfg_nxt.hold_ticks    = pwdata[15:0];
        REG_CONFIRM_COUNT: cfg_nxt.confirm_count = pwdata[3:0];
        REG_INVALID_LIMIT: cfg_nxt.invalid_limit = pwdata[12:0];
        default:           cfg_nxt = cfg_r;  // unmapped, ignored
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_HOLD_TICKS:    prdata = {16'd0, cfg_r.hold_ticks};
      REG_CONFIRM_COUNT: prdata = {28'd0, cfg_r.confirm_count};
      REG_INVALID_LIMIT: prdata = {19'd0, cfg_r.invalid_limit};
      default:           prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.hold_ticks    <= HOLD_TICKS_RESET;
      cfg_r.confirm_count <= CONFIRM_COUNT_RESET;
      cfg_r.invalid_limit <= INVALID_LIMIT_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // ---------------------------------------------------------------
  // front end -> queue -> back end
  // ---------------------------------------------------------------
  logic        push;
  logic        q_full;
  logic        pop;
  atpd_entry_t push_entry;
  atpd_q_out_t q_out;

  // front: classify ambient into a band, push into the queue
  atpd_front u_front (
    .in_valid   (in_valid),
    .in_data    (in_data),
    .q_full     (q_full),
    .in_stall   (in_stall),
    .push       (push),
    .push_entry (push_entry)
  );

  atpd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .full       (q_full),
    .q_out      (q_out)
  );

  // back: detector state and the registered result word
  atpd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_out     (q_out),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
